/* sv/sensor_reading_statistics_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the sensor reading statistics block
// Clocked property checks; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef SENSOR_READING_STATISTICS_ASSERT_SVH
`define SENSOR_READING_STATISTICS_ASSERT_SVH

`ifndef SYNTHESIS
`define SRS_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SRS_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRS_ASSERT_CLK(lbl, prop, msg)
`define SRS_ASSERT_RST(lbl, prop, msg)
`endif

`endif

/* sv/srs_pkg.sv */
// ---------------------------------------------------------------------------
// srs_pkg
// Shared types and constants of the sensor reading statistics block.
// ---------------------------------------------------------------------------
package srs_pkg;

	localparam int DATA_W    = 16;
	localparam int VAL_W     = 15;
	localparam int FIELD_W   = 8;
	localparam int REG_IDX_W = 2;
	localparam int OUT_W     = 128;

	localparam logic [REG_IDX_W-1:0] REG_ALARM    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_NORMAL   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_WARNING  = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_CRITICAL = 2'd3;

	localparam logic signed [DATA_W-1:0] ALARM_RST    = 16'sd720;
	localparam logic signed [DATA_W-1:0] NORMAL_RST   = 16'sd464;
	localparam logic signed [DATA_W-1:0] WARNING_RST  = 16'sd704;
	localparam logic signed [DATA_W-1:0] CRITICAL_RST = 16'sd944;

	// first field in the lowest bits, so members run high to low
	typedef struct packed {
		logic [FIELD_W-1:0]       shutdown_count;
		logic [FIELD_W-1:0]       critical_count;
		logic [FIELD_W-1:0]       warning_count;
		logic [FIELD_W-1:0]       normal_count;
		logic signed [DATA_W-1:0] first_alarm_value;
		logic [FIELD_W-1:0]       first_alarm_index;
		logic [VAL_W-1:0]         average_value;
		logic [VAL_W-1:0]         max_value;
		logic [VAL_W-1:0]         min_value;
		logic [FIELD_W-1:0]       valid_count;
		logic [FIELD_W-1:0]       error_count;
		logic [FIELD_W-1:0]       total_count;
	} report_t;

	localparam int REPORT_W = $bits(report_t);

	typedef struct packed {
		logic accept;
		logic snap;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic div_last;
	} status_t;

endpackage

/* sv/sensor_reading_statistics.sv */
// ---------------------------------------------------------------------------
// sensor_reading_statistics
// Per-set statistics over a stream of signed temperature readings.
// ---------------------------------------------------------------------------
// One reading is taken per clock. A reading marked last closes the set: the
// input then stalls while a restoring divider forms the average one quotient
// bit per cycle over SUM_W = clog2(MAX_ITEMS+1) + 15 quotient bits, and while
// the previous report still waits on the output. The report sits in an output
// register, so readings are taken while it waits. Counters saturate at MAX_ITEMS.
// ---------------------------------------------------------------------------
module sensor_reading_statistics #(
	parameter int MAX_ITEMS = 128
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [srs_pkg::DATA_W-1:0]        s_tdata,  // reading
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// total_count, error_count, valid_count, min_value, max_value,
	// average_value, first_alarm_index, first_alarm_value, normal_count,
	// warning_count, critical_count, shutdown_count, zero pad
	output logic [srs_pkg::OUT_W-1:0]         m_tdata,
	input  logic                              cfg_en,
	input  logic [srs_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [srs_pkg::DATA_W-1:0]        cfg_data
);

	srs_pkg::cmd_t    cmd;
	srs_pkg::status_t stat;
	srs_pkg::report_t report;

	srs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	srs_dp #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.reading   (s_tdata),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.report    (report)
	);

	assign m_tdata = {(srs_pkg::OUT_W - srs_pkg::REPORT_W)'(0), report};

endmodule

/* sv/srs_ctrl.sv */
// ---------------------------------------------------------------------------
// srs_ctrl
// Controller: input acceptance, divide sequencing and output handshake.
// ---------------------------------------------------------------------------
`include "sensor_reading_statistics_assert.svh"

module srs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tlast,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  srs_pkg::status_t stat,
	output srs_pkg::cmd_t    cmd
);

	localparam logic [1:0] ST_RUN  = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       m_tvalid_q;
	logic       out_free;

	assign s_tready = (state_q == ST_RUN);
	assign m_tvalid = m_tvalid_q;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		cmd.accept   = s_tvalid && s_tready;
		cmd.snap     = s_tvalid && s_tready && s_tlast;
		cmd.div_step = (state_q == ST_DIV);
		cmd.load_out = (state_q == ST_HOLD) && out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_RUN: begin
				if (cmd.snap)
					state_d = ST_DIV;
			end
			ST_DIV: begin
				if (stat.div_last)
					state_d = ST_HOLD;
			end
			ST_HOLD: begin
				if (out_free)
					state_d = ST_RUN;
			end
			default: state_d = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_RUN;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	`SRS_ASSERT_CLK(a_last_starts_div, cmd.snap |=> state_q == ST_DIV, "last item did not start divide")
	`SRS_ASSERT_CLK(a_div_holds, (state_q == ST_DIV && !stat.div_last) |=> state_q == ST_DIV, "divide cut short")
	`SRS_ASSERT_CLK(a_out_after_div, $rose(m_tvalid) |-> $past(state_q) == ST_HOLD, "report without divide")
	`SRS_ASSERT_RST(a_no_out_in_reset, !arst_n |=> !m_tvalid, "output valid in reset")

endmodule

/* sv/srs_dp.sv */
// ---------------------------------------------------------------------------
// srs_dp
// Datapath: running statistics, report snapshot, restoring divider and
// output register.
// ---------------------------------------------------------------------------
module srs_dp #(
	parameter int MAX_ITEMS = 128
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  srs_pkg::cmd_t                     cmd,
	output srs_pkg::status_t                  stat,
	input  logic signed [srs_pkg::DATA_W-1:0] reading,
	input  logic                              cfg_en,
	input  logic [srs_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [srs_pkg::DATA_W-1:0]        cfg_data,
	output srs_pkg::report_t                  report
);

	localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
	localparam int SUM_W  = CNT_W + srs_pkg::VAL_W;
	localparam int STEP_W = $clog2(SUM_W + 1);

	logic signed [srs_pkg::DATA_W-1:0] alarm_q, normal_q, warning_q, critical_q;

	logic [CNT_W-1:0]                  pos_q, fault_q, good_q, alarm_pos_q;
	logic [srs_pkg::VAL_W-1:0]         min_q, max_q;
	logic [SUM_W-1:0]                  sum_q;
	logic signed [srs_pkg::DATA_W-1:0] alarm_val_q;
	logic [CNT_W-1:0]                  band_q [4];

	logic [CNT_W-1:0]                  pos_n, fault_n, good_n, alarm_pos_n;
	logic [srs_pkg::VAL_W-1:0]         min_n, max_n;
	logic [SUM_W-1:0]                  sum_n;
	logic signed [srs_pkg::DATA_W-1:0] alarm_val_n;
	logic [CNT_W-1:0]                  band_n [4];

	logic                      upd;
	logic                      neg;
	logic [srs_pkg::VAL_W-1:0] rv;
	logic [1:0]                band_sel;

	srs_pkg::report_t rep_q;
	srs_pkg::report_t rep_avg;
	srs_pkg::report_t out_q;

	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W:0]    rem_sh;
	logic              ge;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_q    <= srs_pkg::ALARM_RST;
			normal_q   <= srs_pkg::NORMAL_RST;
			warning_q  <= srs_pkg::WARNING_RST;
			critical_q <= srs_pkg::CRITICAL_RST;
		end else if (cfg_en) begin
			case (cfg_index)
				srs_pkg::REG_ALARM:    alarm_q    <= cfg_data;
				srs_pkg::REG_NORMAL:   normal_q   <= cfg_data;
				srs_pkg::REG_WARNING:  warning_q  <= cfg_data;
				srs_pkg::REG_CRITICAL: critical_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// next statistics for the item on the input
	assign upd = pos_q < CNT_W'(MAX_ITEMS);
	assign neg = reading[srs_pkg::DATA_W-1];
	assign rv  = reading[srs_pkg::VAL_W-1:0];

	always_comb begin
		if (reading <= normal_q)
			band_sel = 2'd0;
		else if (reading <= warning_q)
			band_sel = 2'd1;
		else if (reading <= critical_q)
			band_sel = 2'd2;
		else
			band_sel = 2'd3;
	end

	always_comb begin
		pos_n       = pos_q;
		fault_n     = fault_q;
		good_n      = good_q;
		alarm_pos_n = alarm_pos_q;
		alarm_val_n = alarm_val_q;
		min_n       = min_q;
		max_n       = max_q;
		sum_n       = sum_q;
		for (int i = 0; i < 4; i++)
			band_n[i] = band_q[i];
		if (upd) begin
			pos_n = pos_q + 1'b1;
			if (alarm_pos_q == '0 && reading >= alarm_q) begin
				alarm_pos_n = pos_q + 1'b1;
				alarm_val_n = reading;
			end
			if (neg) begin
				fault_n = fault_q + 1'b1;
			end else begin
				if (good_q == '0 || rv < min_q)
					min_n = rv;
				if (good_q == '0 || rv > max_q)
					max_n = rv;
				sum_n            = sum_q + SUM_W'(rv);
				good_n           = good_q + 1'b1;
				band_n[band_sel] = band_q[band_sel] + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			fault_q     <= '0;
			good_q      <= '0;
			alarm_pos_q <= '0;
			alarm_val_q <= '0;
			min_q       <= '0;
			max_q       <= '0;
			sum_q       <= '0;
			for (int i = 0; i < 4; i++)
				band_q[i] <= '0;
		end else if (cmd.snap) begin
			pos_q       <= '0;
			fault_q     <= '0;
			good_q      <= '0;
			alarm_pos_q <= '0;
			alarm_val_q <= '0;
			min_q       <= '0;
			max_q       <= '0;
			sum_q       <= '0;
			for (int i = 0; i < 4; i++)
				band_q[i] <= '0;
		end else if (cmd.accept) begin
			pos_q       <= pos_n;
			fault_q     <= fault_n;
			good_q      <= good_n;
			alarm_pos_q <= alarm_pos_n;
			alarm_val_q <= alarm_val_n;
			min_q       <= min_n;
			max_q       <= max_n;
			sum_q       <= sum_n;
			for (int i = 0; i < 4; i++)
				band_q[i] <= band_n[i];
		end
	end

	// report snapshot and restoring divider, one quotient bit a cycle
	assign rem_sh = {rem_q, quo_q[SUM_W-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};
	assign stat.div_last = (step_q == STEP_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= '0;
		else if (cmd.snap)
			step_q <= STEP_W'(SUM_W);
		else if (cmd.div_step && step_q != '0)
			step_q <= step_q - 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.snap) begin
			rep_q.total_count       <= srs_pkg::FIELD_W'(pos_n);
			rep_q.error_count       <= srs_pkg::FIELD_W'(fault_n);
			rep_q.valid_count       <= srs_pkg::FIELD_W'(good_n);
			rep_q.min_value         <= min_n;
			rep_q.max_value         <= max_n;
			rep_q.average_value     <= '0;
			rep_q.first_alarm_index <= srs_pkg::FIELD_W'(alarm_pos_n);
			rep_q.first_alarm_value <= alarm_val_n;
			rep_q.normal_count      <= srs_pkg::FIELD_W'(band_n[0]);
			rep_q.warning_count     <= srs_pkg::FIELD_W'(band_n[1]);
			rep_q.critical_count    <= srs_pkg::FIELD_W'(band_n[2]);
			rep_q.shutdown_count    <= srs_pkg::FIELD_W'(band_n[3]);
			quo_q                   <= sum_n;
			rem_q                   <= '0;
			dvs_q                   <= good_n;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= ge ? CNT_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[CNT_W-1:0];
		end
	end

	// no valid reading: sum is zero, average forced to zero
	always_comb begin
		rep_avg               = rep_q;
		rep_avg.average_value = (dvs_q == '0) ? '0 : quo_q[srs_pkg::VAL_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out)
			out_q <= rep_avg;
	end

	assign report = out_q;

endmodule

/* dv/sensor_reading_statistics_tb.sv */
// ---------------------------------------------------------------------------
// sensor_reading_statistics_tb
// Self-checking bench for the sensor reading statistics block. Readings are
// streamed in sets closed by tlast, in bursts with random gaps, while the
// report side stalls on its own pattern. Each accepted item is folded into a
// local model of the set statistics, and every report is compared field by
// field. Band limits and the alarm level are reprogrammed between phases,
// extremes and unordered limits included, and long sets push the counters
// into saturation.
// ---------------------------------------------------------------------------
module sensor_reading_statistics_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import srs_pkg::*;

	localparam int MAX_ITEMS   = 128;
	localparam int SETTLE      = 40;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic signed [DATA_W-1:0] reading;
		logic                     last;
	} reading_item_t;

	typedef enum int {BAND_NORMAL, BAND_WARNING, BAND_CRITICAL, BAND_SHUTDOWN} band_e;
	typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_ONE_IN_FOUR, RDY_MOSTLY} ready_mode_e;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [DATA_W-1:0]    s_tdata   = '0;
	logic                 s_tlast   = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [OUT_W-1:0]     m_tdata;
	logic                 cfg_en    = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0]    cfg_data  = '0;

	reading_item_t pending_readings[$];
	report_t       expected_reports[$];

	logic signed [DATA_W-1:0] limit_reg [4];

	int                       set_position;
	int                       set_errors;
	int                       set_valid;
	logic signed [DATA_W-1:0] set_min;
	logic signed [DATA_W-1:0] set_max;
	int                       set_sum;
	int                       alarm_index;
	logic signed [DATA_W-1:0] alarm_value;
	int                       band_count [4];

	int mismatches      = 0;
	int reports_checked = 0;
	int readings_sent   = 0;
	int sets_closed     = 0;
	int saturated_sets  = 0;
	int reg_writes      = 0;
	int hold_reqs       = 0;
	int hold_done       = 0;
	int idle_cycles     = 0;

	int          burst_left = 0;
	int          gap_left   = 0;
	int          hold_left  = 0;
	int          mode_left  = 0;
	int          stall_tick = 0;
	ready_mode_e ready_mode = RDY_ALWAYS;

	report_t got_report;
	report_t want_report;

	sensor_reading_statistics u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic clear_set();
		set_position = 0;
		set_errors   = 0;
		set_valid    = 0;
		set_min      = '0;
		set_max      = '0;
		set_sum      = 0;
		alarm_index  = 0;
		alarm_value  = '0;
		foreach (band_count[i])
			band_count[i] = 0;
	endtask

	task automatic fold_reading(input logic signed [DATA_W-1:0] r, input logic lst);
		report_t rep;
		int      avg;
		if (set_position < MAX_ITEMS) begin
			set_position++;
			if (alarm_index == 0 && r >= limit_reg[REG_ALARM]) begin
				alarm_index = set_position;
				alarm_value = r;
			end
			if (r < 0) begin
				set_errors++;
			end else begin
				if (set_valid == 0) begin
					set_min = r;
					set_max = r;
				end else begin
					if (r < set_min)
						set_min = r;
					if (r > set_max)
						set_max = r;
				end
				set_sum += r;
				set_valid++;
				if (r <= limit_reg[REG_NORMAL])
					band_count[BAND_NORMAL]++;
				else if (r <= limit_reg[REG_WARNING])
					band_count[BAND_WARNING]++;
				else if (r <= limit_reg[REG_CRITICAL])
					band_count[BAND_CRITICAL]++;
				else
					band_count[BAND_SHUTDOWN]++;
			end
		end
		if (lst) begin
			avg = (set_valid != 0) ? set_sum / set_valid : 0;
			rep.total_count       = FIELD_W'(set_position);
			rep.error_count       = FIELD_W'(set_errors);
			rep.valid_count       = FIELD_W'(set_valid);
			rep.min_value         = set_min[VAL_W-1:0];
			rep.max_value         = set_max[VAL_W-1:0];
			rep.average_value     = VAL_W'(avg);
			rep.first_alarm_index = FIELD_W'(alarm_index);
			rep.first_alarm_value = alarm_value;
			rep.normal_count      = FIELD_W'(band_count[BAND_NORMAL]);
			rep.warning_count     = FIELD_W'(band_count[BAND_WARNING]);
			rep.critical_count    = FIELD_W'(band_count[BAND_CRITICAL]);
			rep.shutdown_count    = FIELD_W'(band_count[BAND_SHUTDOWN]);
			expected_reports.push_back(rep);
			sets_closed++;
			if (set_position == MAX_ITEMS)
				saturated_sets++;
			clear_set();
		end
	endtask

	// sender: bursts of random length, random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				fold_reading(s_tdata, s_tlast);
				void'(pending_readings.pop_front());
				readings_sent++;
			end
			if (!(s_tvalid && !s_tready)) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_readings.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pending_readings[0].reading;
					s_tlast  <= pending_readings[0].last;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern of its own, plus long hold-offs on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (hold_done != hold_reqs) begin
				hold_done++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					ready_mode = ready_mode_e'($urandom_range(0, 3));
					mode_left  = $urandom_range(16, 96);
				end else begin
					mode_left--;
				end
				stall_tick++;
				case (ready_mode)
					RDY_ALWAYS:      m_tready <= 1'b1;
					RDY_COIN:        m_tready <= 1'($urandom_range(0, 1));
					RDY_ONE_IN_FOUR: m_tready <= (stall_tick % 4 == 0);
					default:         m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	task automatic check_field(input string nm, input logic [DATA_W-1:0] want_v,
			input logic [DATA_W-1:0] got_v);
		if (got_v !== want_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("report %0d: %s expected %0h got %0h", reports_checked, nm,
					want_v, got_v);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected report %0h", m_tdata);
			end else begin
				want_report = expected_reports.pop_front();
				got_report  = m_tdata[REPORT_W-1:0];
				check_field("total_count", want_report.total_count, got_report.total_count);
				check_field("error_count", want_report.error_count, got_report.error_count);
				check_field("valid_count", want_report.valid_count, got_report.valid_count);
				check_field("min_value", want_report.min_value, got_report.min_value);
				check_field("max_value", want_report.max_value, got_report.max_value);
				check_field("average_value", want_report.average_value,
					got_report.average_value);
				check_field("first_alarm_index", want_report.first_alarm_index,
					got_report.first_alarm_index);
				check_field("first_alarm_value", want_report.first_alarm_value,
					got_report.first_alarm_value);
				check_field("normal_count", want_report.normal_count,
					got_report.normal_count);
				check_field("warning_count", want_report.warning_count,
					got_report.warning_count);
				check_field("critical_count", want_report.critical_count,
					got_report.critical_count);
				check_field("shutdown_count", want_report.shutdown_count,
					got_report.shutdown_count);
				check_field("pad", '0, m_tdata[OUT_W-1:REPORT_W]);
			end
			reports_checked++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
					$display("sensor_reading_statistics_tb: FAIL");
					$finish;
				end
			end
		end
	end

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		@(posedge clk);
		cfg_en    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_en <= 1'b0;
		limit_reg[idx] = val;
		reg_writes++;
		@(negedge clk);
	endtask

	task automatic write_limits(input int alarm, input int normal, input int warning,
			input int critical);
		write_reg(REG_ALARM, DATA_W'(alarm));
		write_reg(REG_NORMAL, DATA_W'(normal));
		write_reg(REG_WARNING, DATA_W'(warning));
		write_reg(REG_CRITICAL, DATA_W'(critical));
	endtask

	task automatic settle();
		while (pending_readings.size() != 0 || s_tvalid || expected_reports.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_reading();
		int          sel;
		int          d;
		int          v;
		logic [15:0] raw;
		sel = $urandom_range(0, 99);
		if (sel < 20) begin
			raw = 16'($urandom);
			v   = int'($signed(raw));
		end else if (sel < 50) begin
			v = $urandom_range(0, 1200);
		end else if (sel < 75) begin
			d = $urandom_range(0, 4);
			v = limit_reg[$urandom_range(0, 3)] + d - 2;
		end else if (sel < 85) begin
			d = $urandom_range(1, 2000);
			v = -d;
		end else if (sel < 90) begin
			v = 0;
		end else if (sel < 94) begin
			v = 32767;
		end else if (sel < 97) begin
			v = -32768;
		end else begin
			v = $urandom_range(1000, 32767);
		end
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return DATA_W'(v);
	endfunction

	task automatic push_set(input int n);
		reading_item_t it;
		for (int i = 0; i < n; i++) begin
			it.reading = pick_reading();
			it.last    = (i == n - 1);
			pending_readings.push_back(it);
		end
	endtask

	task automatic push_fixed(input int vals[$]);
		reading_item_t it;
		foreach (vals[i]) begin
			it.reading = DATA_W'(vals[i]);
			it.last    = (i == vals.size() - 1);
			pending_readings.push_back(it);
		end
	endtask

	task automatic run_phase(input int budget, input int short_max);
		int pushed;
		int n;
		pushed = 0;
		while (pushed < budget) begin
			if ($urandom_range(0, 29) == 0)
				n = $urandom_range(MAX_ITEMS - 1, MAX_ITEMS + 12);
			else
				n = $urandom_range(1, short_max);
			push_set(n);
			pushed += n;
		end
		settle();
	endtask

	initial begin
		limit_reg[REG_ALARM]    = ALARM_RST;
		limit_reg[REG_NORMAL]   = NORMAL_RST;
		limit_reg[REG_WARNING]  = WARNING_RST;
		limit_reg[REG_CRITICAL] = CRITICAL_RST;
		clear_set();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed sets under the reset limits, then one under a negative alarm level
		push_fixed('{0});
		push_fixed('{-1});
		push_fixed('{32767, -32768, 464, 465, 704, 705, 944, 945, 719, 720, 1});
		push_fixed('{-5, -32768});
		settle();
		write_reg(REG_ALARM, -16'sd50);
		push_fixed('{-10, -60, 5});
		settle();

		// random phases over a spread of limit settings
		write_limits(720, 464, 704, 944);
		push_set(MAX_ITEMS + 7);
		run_phase(160, 24);
		write_limits(-32768, -32768, -32768, -32768);
		run_phase(160, 24);
		write_limits(32767, 32767, 32767, 32767);
		run_phase(160, 24);
		write_limits(-200, 900, 300, 600);
		run_phase(160, 24);
		write_limits($urandom, $urandom, $urandom, $urandom);
		run_phase(160, 24);
		write_limits(-int'($urandom_range(1, 3000)), $urandom_range(0, 500),
			$urandom_range(400, 900), $urandom_range(800, 2000));
		run_phase(160, 24);

		// long hold-off on the report side while short sets keep arriving
		write_limits(720, 464, 704, 944);
		hold_reqs++;
		run_phase(120, 3);

		write_limits($urandom, $urandom_range(0, 600), $urandom_range(300, 1200),
			$urandom_range(900, 32767));
		run_phase(160, 24);

		settle();
		mismatches += expected_reports.size();
		$display("covered %0d readings in %0d sets (%0d saturated), %0d reports checked",
			readings_sent, sets_closed, saturated_sets, reports_checked);
		$display("%0d register writes, %0d mismatches", reg_writes, mismatches);
		if (mismatches == 0)
			$display("sensor_reading_statistics_tb: PASS");
		else
			$display("sensor_reading_statistics_tb: FAIL");
		$finish;
	end

endmodule
